>>> rtl/windowed_rms_level_meter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed RMS level meter
// Concurrent property wrappers on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_LEVEL_METER_MACROS_SVH
`define WINDOWED_RMS_LEVEL_METER_MACROS_SVH

// Same-cycle implication
`define WRMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WRMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wrms_pkg.sv
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared constants and register indexes of the windowed RMS level meter.
// ----------------------------------------------------------------------------
package wrms_pkg;

    // Default structural parameters
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_SAMPLE_BITS  = 24;
    localparam int DEF_WINDOW_BITS  = 16;

    // Fixed field and register widths
    localparam int SUM_BITS      = 62;
    localparam int ACC_BITS      = 64;
    localparam int WL_BITS       = 16;
    localparam int CC_BITS       = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CHAN_OUT_BITS = 3;

    // Register reset values
    localparam logic [WL_BITS-1:0] WL_RESET = 16'd1024;
    localparam logic [CC_BITS-1:0] CC_RESET = 4'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_MUTED         = 2'd2
    } cfg_reg_t;

endpackage

>>> rtl/windowed_rms_level_meter.sv
// ----------------------------------------------------------------------------
// windowed_rms_level_meter: each sample is accepted, squared and written back in turn.
// Window end: per active channel, a read, a load, the 62-step divider, the 31-step root unit
// and the output; output stalls can hold it. Input is held off meanwhile.
// aresetn (sync, low) restores register defaults and marks all sums empty at once.
// ----------------------------------------------------------------------------
module windowed_rms_level_meter #(
    parameter int MAX_CHANNELS = wrms_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = wrms_pkg::DEF_SAMPLE_BITS,
    parameter int WINDOW_BITS  = wrms_pkg::DEF_WINDOW_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [wrms_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [wrms_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    // sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] rms_level
    output logic [wrms_pkg::CHAN_OUT_BITS-1:0]  m_tuser,   // [2:0] channel
    output logic                                m_tlast    // last result of window
);
    import wrms_pkg::*;

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_CHANNELS + 1);
    localparam int CW_BITS   = ((CC_BITS > CNT_BITS) ? CC_BITS : CNT_BITS) + 1;
    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int ITER_BITS = $clog2(SUM_BITS);
    localparam int FCMP_BITS = (WINDOW_BITS > WL_BITS) ? WINDOW_BITS : WL_BITS;
    localparam int RCMP_BITS = 33;

    localparam logic [SUM_BITS-1:0]  SUM_MAX = '1;
    localparam logic [RCMP_BITS-1:0] RMS_MAX = RCMP_BITS'(1) << (SAMPLE_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_RD,
        S_LOAD,
        S_DIV,
        S_SQRT,
        S_OUT
    } state_t;

    // Control registers
    state_t                   state_reg;
    logic [WL_BITS-1:0]       wl_reg;
    logic [CC_BITS-1:0]       cc_reg;
    logic                     muted_reg;
    logic [WINDOW_BITS-1:0]   fc_reg;
    logic [CH_BITS-1:0]       pos_reg;
    logic [MAX_CHANNELS-1:0]  valid_reg;
    logic [CH_BITS-1:0]       k_reg;
    logic [ITER_BITS-1:0]     iter_reg;
    logic                     m_tvalid_reg;

    // Datapath registers
    logic [CH_BITS-1:0]       ch_reg;
    logic [SAMPLE_BITS-1:0]   mag_reg;
    logic [SQ_BITS-1:0]       sq_reg;
    logic [SUM_BITS-1:0]      rd_data_reg;
    logic [SUM_BITS-1:0]      dq_reg;
    logic [WL_BITS-1:0]       rem_reg;
    logic [ROOT_BITS:0]       srem_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [DATA_BITS-1:0]     m_tdata_reg;
    logic [CHAN_OUT_BITS-1:0] m_tuser_reg;
    logic                     m_tlast_reg;

    // Channel sums memory
    logic [SUM_BITS-1:0]      sums_mem [MAX_CHANNELS];

    // Combinational signals
    logic [CW_BITS-1:0]       cc_wide;
    logic [CNT_BITS-1:0]      act_cnt;
    logic [WL_BITS-1:0]       wl_eff;
    logic                     take;
    logic [SAMPLE_BITS-1:0]   sample;
    logic [SAMPLE_BITS-1:0]   mag_next;
    logic [CH_BITS-1:0]       ch_start;
    logic                     mem_rd_en;
    logic [CH_BITS-1:0]       mem_rd_addr;
    logic                     mem_wr_en;
    logic [SUM_BITS-1:0]      sum_old;
    logic [ACC_BITS-1:0]      acc_sum;
    logic [SUM_BITS-1:0]      sum_next;
    logic [CNT_BITS-1:0]      ch_inc;
    logic                     frame_wrap;
    logic [CH_BITS-1:0]       pos_next;
    logic [WINDOW_BITS-1:0]   fc_after;
    logic                     window_end;
    logic [WINDOW_BITS-1:0]   fc_next;
    logic [WL_BITS:0]         div_trial;
    logic                     div_ge;
    logic [WL_BITS:0]         div_diff;
    logic [WL_BITS-1:0]       rem_step;
    logic [SUM_BITS-1:0]      quo_step;
    logic [ROOT_BITS+2:0]     sq_trial_rem;
    logic [ROOT_BITS+2:0]     sq_trial_sub;
    logic                     sq_ge;
    logic [ROOT_BITS+2:0]     sq_diff;
    logic [ROOT_BITS:0]       srem_step;
    logic [ROOT_BITS-1:0]     root_step;
    logic [SAMPLE_BITS-1:0]   rms_sat;
    logic                     out_last;
    logic                     out_load;

    // Effective channel count and window length
    always_comb begin
        cc_wide = CW_BITS'(cc_reg);
        if (cc_reg == '0) begin
            act_cnt = CNT_BITS'(1);
        end else if (cc_wide > CW_BITS'(MAX_CHANNELS)) begin
            act_cnt = CNT_BITS'(MAX_CHANNELS);
        end else begin
            act_cnt = cc_wide[CNT_BITS-1:0];
        end
        wl_eff = (wl_reg == '0) ? WL_BITS'(1) : wl_reg;
    end

    // Input request: magnitude and starting channel
    assign s_tready = (state_reg == S_IDLE);
    assign take     = s_tvalid && s_tready && !muted_reg;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign mag_next = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
    assign ch_start = (CNT_BITS'(pos_reg) >= act_cnt) ? '0 : pos_reg;

    // Memory port control
    assign mem_rd_en   = take || (state_reg == S_RD);
    assign mem_rd_addr = (state_reg == S_RD) ? k_reg : ch_start;
    assign mem_wr_en   = (state_reg == S_ACC);

    // Saturating accumulate, position and frame count
    always_comb begin
        sum_old    = valid_reg[ch_reg] ? rd_data_reg : '0;
        acc_sum    = ACC_BITS'(sum_old) + ACC_BITS'(sq_reg);
        sum_next   = (acc_sum > ACC_BITS'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_BITS-1:0];
        ch_inc     = CNT_BITS'(ch_reg) + CNT_BITS'(1);
        frame_wrap = (ch_inc >= act_cnt);
        pos_next   = frame_wrap ? '0 : ch_inc[CH_BITS-1:0];
        fc_after   = frame_wrap ? (fc_reg + WINDOW_BITS'(1)) : fc_reg;
        window_end = (FCMP_BITS'(fc_after) >= FCMP_BITS'(wl_eff));
    end

    // Restoring divider step: one quotient bit
    always_comb begin
        div_trial = {rem_reg, dq_reg[SUM_BITS-1]};
        div_diff  = div_trial - {1'b0, wl_eff};
        div_ge    = (div_trial >= {1'b0, wl_eff});
        rem_step  = div_ge ? div_diff[WL_BITS-1:0] : div_trial[WL_BITS-1:0];
        quo_step  = {dq_reg[SUM_BITS-2:0], div_ge};
    end

    // Digit-by-digit root step: one root bit per two radicand bits
    always_comb begin
        sq_trial_rem = {srem_reg, dq_reg[SUM_BITS-1 -: 2]};
        sq_trial_sub = (ROOT_BITS+3)'({root_reg, 2'b01});
        sq_diff      = sq_trial_rem - sq_trial_sub;
        sq_ge        = (sq_trial_rem >= sq_trial_sub);
        srem_step    = sq_ge ? sq_diff[ROOT_BITS:0] : sq_trial_rem[ROOT_BITS:0];
        root_step    = {root_reg[ROOT_BITS-2:0], sq_ge};
    end

    // Result saturation and output hand-over
    assign rms_sat  = (RCMP_BITS'(root_reg) > RMS_MAX) ? RMS_MAX[SAMPLE_BITS-1:0]
                                                         : SAMPLE_BITS'(root_reg);
    assign out_last = ((CNT_BITS'(k_reg) + CNT_BITS'(1)) == act_cnt);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // Frame count next value; a window write at or below the count clears it
    always_comb begin
        fc_next = fc_reg;
        if (state_reg == S_ACC) begin
            fc_next = fc_after;
        end
        if (out_load && out_last) begin
            fc_next = '0;
        end
        if (cfg_wr_en && (cfg_index == REG_WINDOW_LENGTH) &&
            (FCMP_BITS'(fc_next) >= FCMP_BITS'(cfg_wr_data[WL_BITS-1:0]))) begin
            fc_next = '0;
        end
    end

    // Sums memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            sums_mem[ch_reg] <= sum_next;
        end
        if (mem_rd_en) begin
            rd_data_reg <= sums_mem[mem_rd_addr];
        end
    end

    // Sequencer, configuration and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wl_reg       <= WL_RESET;
            cc_reg       <= CC_RESET;
            muted_reg    <= 1'b0;
            fc_reg       <= '0;
            pos_reg      <= '0;
            valid_reg    <= '0;
            k_reg        <= '0;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fc_reg <= fc_next;

            // configuration writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: wl_reg    <= cfg_wr_data[WL_BITS-1:0];
                    REG_CHANNEL_COUNT: cc_reg    <= cfg_wr_data[CC_BITS-1:0];
                    REG_MUTED:         muted_reg <= cfg_wr_data[0];
                    default:           ;
                endcase
            end

            // output register drains on request taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        ch_reg    <= ch_start;
                        mag_reg   <= mag_next;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    sq_reg    <= SQ_BITS'(mag_reg) * SQ_BITS'(mag_reg);
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    valid_reg[ch_reg] <= 1'b1;
                    pos_reg           <= pos_next;
                    k_reg             <= '0;
                    state_reg         <= window_end ? S_RD : S_IDLE;
                end
                S_RD: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    dq_reg    <= valid_reg[k_reg] ? rd_data_reg : '0;
                    rem_reg   <= '0;
                    iter_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    dq_reg  <= quo_step;
                    rem_reg <= rem_step;
                    if (iter_reg == ITER_BITS'(SUM_BITS - 1)) begin
                        iter_reg  <= '0;
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        state_reg <= S_SQRT;
                    end else begin
                        iter_reg <= iter_reg + ITER_BITS'(1);
                    end
                end
                S_SQRT: begin
                    dq_reg   <= {dq_reg[SUM_BITS-3:0], 2'b00};
                    srem_reg <= srem_step;
                    root_reg <= root_step;
                    iter_reg <= iter_reg + ITER_BITS'(1);
                    if (iter_reg == ITER_BITS'(ROOT_BITS - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tdata_reg <= DATA_BITS'(rms_sat);
                        m_tuser_reg <= CHAN_OUT_BITS'(k_reg);
                        m_tlast_reg <= out_last;
                        if (out_last) begin
                            valid_reg <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg + CH_BITS'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    `include "windowed_rms_level_meter_macros.svh"

    // closing a window empties every sum and the frame count
    `WRMS_ASSERT_NXT(a_window_clear, aclk, aresetn, out_load && out_last, (valid_reg == '0) && (fc_reg == '0), "window end left sums or frame count")

    // channel position stays inside the active channels after write-back
    `WRMS_ASSERT_NXT(a_pos_range, aclk, aresetn, (state_reg == S_ACC) && !cfg_wr_en, CNT_BITS'(pos_reg) < act_cnt, "channel position beyond active count")

    // a delivered level never exceeds full scale
    `WRMS_ASSERT_IMP(a_rms_range, aclk, aresetn, m_tvalid, RCMP_BITS'(m_tdata[SAMPLE_BITS-1:0]) <= RMS_MAX, "rms level above full scale")

endmodule

>>> verif/windowed_rms_level_meter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_level_meter_test
// Streams interleaved samples into the meter under changing window length,
// channel count and mute settings, with random gaps and back-pressure on both
// streams. A scoreboard keeps its own copy of the sums and counters, predicts
// every per-channel RMS level and compares each one field by field.
// ----------------------------------------------------------------------------
module windowed_rms_level_meter_test;
    import wrms_pkg::*;

    localparam int          NCH            = DEF_MAX_CHANNELS;
    localparam int          SETTLE         = 16;
    localparam int          RANDOM_SAMPLES = 290;
    localparam logic [63:0] SUM_LIMIT      = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] RMS_CEIL       = 32'd8388608;

    typedef struct packed {
        logic [23:0] level;
        logic [2:0]  chan;
        logic        last;
    } rms_result_t;

    // Scoreboard: running sums per channel and the queue of awaited levels
    class rms_scoreboard;
        logic [SUM_BITS-1:0] acc [NCH];
        logic [WL_BITS-1:0]  frames;
        int                  slot;
        logic [WL_BITS-1:0]  win_len;
        logic [CC_BITS-1:0]  chans;
        logic                mute;
        rms_result_t         pending_levels [$];
        int                  errors;

        function new();
            foreach (acc[i]) acc[i] = '0;
            frames  = '0;
            slot    = 0;
            win_len = WL_RESET;
            chans   = CC_RESET;
            mute    = 1'b0;
            errors  = 0;
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 20) $display("%0t ns: mismatch: %s", $time, what);
        endfunction

        function void set_register(cfg_reg_t idx, logic [15:0] value);
            case (idx)
                REG_WINDOW_LENGTH: begin
                    win_len = value;
                    // shrinking to or below the count restarts the window
                    if (frames >= win_len) frames = '0;
                end
                REG_CHANNEL_COUNT: chans = value[CC_BITS-1:0];
                REG_MUTED:         mute  = value[0];
                default: ;
            endcase
        endfunction

        // bit-by-bit integer square root, operand below 2^62
        function logic [31:0] floor_root(logic [63:0] v);
            logic [31:0] r;
            logic [31:0] t;
            r = '0;
            for (int b = 30; b >= 0; b--) begin
                t = r | (32'd1 << b);
                if (64'(t) * 64'(t) <= v) r = t;
            end
            return r;
        endfunction

        function void note_sample(logic [23:0] s);
            logic [23:0]        mag;
            logic [63:0]        sq;
            logic [31:0]        root;
            logic [WL_BITS-1:0] wl;
            int                 n;
            rms_result_t        res;
            if (mute) return;
            n   = (chans == 0) ? 1 : (chans > NCH) ? NCH : int'(chans);
            wl  = (win_len == 0) ? WL_BITS'(1) : win_len;
            mag = s[23] ? (~s + 24'd1) : s;
            sq  = 64'(mag) * 64'(mag);

            // channel count lowered mid-frame: drop the partial frame
            if (slot >= n) slot = 0;
            if (64'(acc[slot]) > SUM_LIMIT - sq) acc[slot] = SUM_BITS'(SUM_LIMIT);
            else acc[slot] = acc[slot] + SUM_BITS'(sq);

            slot++;
            if (slot >= n) begin
                slot   = 0;
                frames = frames + 1'b1;
            end

            // window complete: one level per active channel, then clear all
            if (frames >= wl) begin
                for (int k = 0; k < n; k++) begin
                    root = floor_root(64'(acc[k]) / 64'(wl));
                    if (root > RMS_CEIL) root = RMS_CEIL;
                    res.level = root[23:0];
                    res.chan  = 3'(k);
                    res.last  = (k == n - 1);
                    pending_levels.push_back(res);
                end
                foreach (acc[i]) acc[i] = '0;
                frames = '0;
            end
        endfunction

        function void check_result(rms_result_t got);
            rms_result_t want;
            if (pending_levels.size() == 0) begin
                report($sformatf("unexpected level %0d on channel %0d, last %0b",
                                 got.level, got.chan, got.last));
                return;
            end
            want = pending_levels.pop_front();
            if (got.level !== want.level)
                report($sformatf("channel %0d level %0d, want %0d",
                                 want.chan, got.level, want.level));
            if (got.chan !== want.chan)
                report($sformatf("channel %0d, want %0d", got.chan, want.chan));
            if (got.last !== want.last)
                report($sformatf("channel %0d last %0b, want %0b",
                                 want.chan, got.last, want.last));
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [23:0]              s_tdata;   // [23:0] sample
    logic                     m_tvalid;
    logic                     m_tready;
    logic [23:0]              m_tdata;   // [23:0] rms_level
    logic [CHAN_OUT_BITS-1:0] m_tuser;   // [2:0] channel
    logic                     m_tlast;

    rms_scoreboard sb;
    bit            tx_burst;
    bit            rx_burst;

    windowed_rms_level_meter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Register write, then write enable low again before the task returns
    task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        sb.set_register(idx, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One sample request; valid stays high across back-to-back requests
    task automatic send_sample(logic [23:0] s);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_sample(s);
    endtask

    // Drain: every awaited level in, then let the sample path empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'($urandom_range(0, 15)) - 24'd8;
            3:       return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    // Result sink with random back-pressure
    initial begin : result_sink
        int          stall;
        rms_result_t got;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got.level = m_tdata;
            got.chan  = m_tuser;
            got.last  = m_tlast;
            sb.check_result(got);
        end
    end

    // Stimulus
    initial begin : stimulus
        int          sent;
        int          n_items;
        int          eff_ch;
        int          eff_wl;
        logic [15:0] wl_val;
        logic [15:0] cc_val;
        bit          mute_on;

        sb = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_WINDOW_LENGTH;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one frame into the default window
        send_sample(24'h000123);
        send_sample(24'hFFF000);
        wait_idle();

        // window written at the count: count cleared, sums kept
        write_reg(REG_WINDOW_LENGTH, 16'd1);
        write_reg(REG_CHANNEL_COUNT, 16'd1);
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        wait_idle();

        // muted samples leave no trace
        write_reg(REG_MUTED, 16'd1);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        wait_idle();
        write_reg(REG_MUTED, 16'd0);

        // zero window length and zero channel count act as one
        write_reg(REG_WINDOW_LENGTH, 16'd0);
        write_reg(REG_CHANNEL_COUNT, 16'd0);
        send_sample(24'hFFFFFF);
        send_sample(24'h000001);
        wait_idle();

        // channel count above the maximum, upper data bits ignored
        write_reg(REG_WINDOW_LENGTH, 16'd1);
        write_reg(REG_CHANNEL_COUNT, 16'hFFF9);
        repeat (NCH) send_sample(pick_sample());
        wait_idle();

        // stale sum after a window cut: level saturates
        write_reg(REG_CHANNEL_COUNT, 16'd1);
        write_reg(REG_WINDOW_LENGTH, 16'd5);
        repeat (4) send_sample(24'h800000);
        wait_idle();
        write_reg(REG_WINDOW_LENGTH, 16'd1);
        send_sample(24'h800000);
        wait_idle();

        // partial frame abandoned by a lower channel count; upper sums cleared
        write_reg(REG_CHANNEL_COUNT, 16'd4);
        write_reg(REG_WINDOW_LENGTH, 16'd2);
        repeat (3) send_sample(pick_sample());
        wait_idle();
        write_reg(REG_CHANNEL_COUNT, 16'd2);
        repeat (4) send_sample(pick_sample());
        wait_idle();
        write_reg(REG_CHANNEL_COUNT, 16'd3);
        write_reg(REG_WINDOW_LENGTH, 16'd1);
        repeat (3) send_sample(pick_sample());
        wait_idle();

        // longest window, only touched
        write_reg(REG_WINDOW_LENGTH, 16'hFFFF);
        send_sample(pick_sample());
        send_sample(pick_sample());
        wait_idle();

        // random phases: new settings, then mostly whole windows
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 9))
                0:       cc_val = 16'd0;
                1:       cc_val = 16'($urandom_range(9, 15)) | (16'($urandom) & 16'hFFF0);
                default: cc_val = 16'($urandom_range(1, NCH));
            endcase
            case ($urandom_range(0, 11))
                0:       wl_val = 16'd0;
                1:       wl_val = 16'hFFFF;
                2:       wl_val = 16'($urandom_range(5, 12));
                default: wl_val = 16'($urandom_range(1, 4));
            endcase
            mute_on = ($urandom_range(0, 7) == 0);
            write_reg(REG_CHANNEL_COUNT, cc_val);
            write_reg(REG_WINDOW_LENGTH, wl_val);
            write_reg(REG_MUTED, {15'd0, mute_on});
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);

            eff_ch = (cc_val[3:0] == 0) ? 1 : (cc_val[3:0] > NCH) ? NCH : int'(cc_val[3:0]);
            eff_wl = (wl_val == 0) ? 1 : int'(wl_val);
            if (eff_wl > 12) n_items = eff_ch * $urandom_range(1, 3);
            else if (eff_wl > 4) n_items = eff_ch * eff_wl;
            else n_items = eff_ch * eff_wl * $urandom_range(1, 3);
            // ragged tail now and then
            if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, 5);

            repeat (n_items) send_sample(pick_sample());
            sent += n_items;
            wait_idle();
        end

        tx_burst = 1'b0;
        rx_burst = 1'b0;
        if (sb.errors == 0) begin
            $display("windowed_rms_level_meter_test: PASS");
        end else begin
            $display("windowed_rms_level_meter_test: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(64'd20_000_000);
        $display("windowed_rms_level_meter_test: FAIL");
        $finish;
    end

endmodule

>>> windowed_rms_level_meter.f
+incdir+rtl
rtl/wrms_pkg.sv
rtl/windowed_rms_level_meter.sv
verif/windowed_rms_level_meter_test.sv
